// File: rtl/ucrf_pkg.sv
package ucrf_pkg;

	// Request kinds carried on the input tuser.
	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_DATA  = 2'd1,
		REQ_RX    = 2'd2
	} req_e_t;

	// Result kinds carried on the output tuser.
	typedef enum logic [1:0] {
		KIND_TX      = 2'd0,
		KIND_RX_DATA = 2'd1,
		KIND_DONE    = 2'd2
	} kind_e_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_OVERFLOW    = 4'd1,
		ST_MISMATCH    = 4'd2,
		ST_UART_ERR    = 4'd3,
		ST_UNSUPPORTED = 4'd4,
		ST_BAD_LENGTH  = 4'd5,
		ST_TOO_LONG    = 4'd6,
		ST_BAD_CHECK   = 4'd7
	} status_e_t;

	// Device error codes found in the first reply data byte.
	localparam logic [7:0] DEV_UART_ERR_LO  = 8'hf1;
	localparam logic [7:0] DEV_UART_ERR_MID = 8'hf2;
	localparam logic [7:0] DEV_UART_ERR_HI  = 8'hf3;
	localparam logic [7:0] DEV_UNSUPPORTED  = 8'hf4;
	localparam logic [7:0] DEV_BAD_LENGTH   = 8'hf5;
	localparam logic [7:0] DEV_TOO_LONG     = 8'hf6;
	localparam logic [7:0] DEV_BAD_CHECK    = 8'hf7;

	// Longest command payload; longer requests are saturated to it.
	localparam logic [6:0] MAX_DATA_BYTES = 7'd32;

	// Bytes of a reply frame beyond its data: header, command, checksum.
	localparam int FRAME_OVERHEAD = 3;

	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		kind_e_t   kind;
		logic [7:0] data;
		status_e_t status;
		logic [6:0] rlen;
	} result_t;

	// All results that one input item causes, in order from index 0.
	typedef struct packed {
		logic [1:0]                 cnt;
		result_t [MAX_RESULTS-1:0] res;
	} bundle_t;

endpackage

// File: rtl/uart_command_reply_framer_unit.sv
// The results of an item are registered in the result queue before they are offered.
// Throughput: one item per cycle while each item causes at most one result and the
// output is not stalled; an item with N results is sent as N output transfers, and a
// two-deep queue of result groups lets the input run ahead of a stalled output by two result groups.
// Reset: arst_n clears the framing state and empties the result queue at once.
module uart_command_reply_framer_unit #(
	parameter int RX_BUFFER_BYTES = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // op_write, cmd_code, data_len, ignore_errors, byte_value
	input  logic [1:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // out_byte, status, reply_length, zero fill
	output logic [1:0]  m_tuser,  // out_kind
	output logic        m_tlast
);
	import ucrf_pkg::*;

	localparam logic [1:0] QDEPTH = 2'd2;

	logic    accept;
	logic    push;
	logic    take;
	logic    pop;
	bundle_t bundle;
	bundle_t head;
	result_t cur;
	bundle_t q_q [2];
	logic    wr_q;
	logic    rd_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;

	assign s_tready = (cnt_q != QDEPTH);
	assign accept   = s_tvalid && s_tready;

	ucrf_engine #(
		.RX_BUFFER_BYTES(RX_BUFFER_BYTES)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (accept),
		.req          (s_tuser),
		.op_write     (s_tdata[0]),
		.cmd_code     (s_tdata[8:1]),
		.data_len     (s_tdata[14:9]),
		.ignore_errors(s_tdata[15]),
		.byte_value   (s_tdata[23:16]),
		.bundle       (bundle)
	);

	// Items that cause no result never enter the queue.
	assign push = accept && (bundle.cnt != 2'd0);

	assign head     = q_q[rd_q];
	assign cur      = head.res[idx_q];
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tlast  = (idx_q == head.cnt - 2'd1);
	assign m_tdata  = {5'b0, cur.rlen, cur.status, cur.data};
	assign m_tuser  = cur.kind;
	assign take     = m_tvalid && m_tready;
	assign pop      = take && m_tlast;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= bundle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q  <= ~rd_q;
				idx_q <= '0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QDEPTH)
		else $error("result queue count out of range");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (idx_q < head.cnt))
		else $error("result index beyond its group");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> (idx_q == 2'd0))
		else $error("result index not cleared while queue is empty");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !m_tlast) |=> (m_tvalid && idx_q == $past(idx_q) + 2'd1))
		else $error("result group interrupted before its last item");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QDEPTH && !pop) |=> (cnt_q == QDEPTH))
		else $error("full queue changed without a pop");
`endif

endmodule

// File: rtl/ucrf_engine.sv
module ucrf_engine #(
	parameter int RX_BUFFER_BYTES = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [1:0]       req,
	input  logic             op_write,
	input  logic [7:0]       cmd_code,
	input  logic [5:0]       data_len,
	input  logic             ignore_errors,
	input  logic [7:0]       byte_value,
	output ucrf_pkg::bundle_t bundle
);
	import ucrf_pkg::*;

	localparam int RW = $clog2(RX_BUFFER_BYTES + 1);
	localparam int CW = 9;
	localparam logic [CW-1:0] RX_LIMIT = CW'(RX_BUFFER_BYTES);
	localparam logic [CW-1:0] OVERHEAD = CW'(FRAME_OVERHEAD);

	logic [RW-1:0] rx_count_q, rx_count_d;
	logic          held_q, held_d;
	logic          rop_q, rop_d;
	logic [6:0]    rlen_q, rlen_d;
	logic [7:0]    rcmd_q, rcmd_d;
	logic [7:0]    rfirst_q, rfirst_d;
	logic          eop_q, eop_d;
	logic [7:0]    ecmd_q, ecmd_d;
	logic          eign_q, eign_d;
	logic [7:0]    tx_sum_q, tx_sum_d;
	logic [5:0]    tx_left_q, tx_left_d;

	always_comb begin
		logic [5:0]    dlen_s;
		logic [7:0]    hdr;
		logic [7:0]    sum_n;
		logic [CW-1:0] idx;
		logic [CW-1:0] rx_n;
		logic [1:0]    n;
		status_e_t     st;

		rx_count_d = rx_count_q;
		held_d     = held_q;
		rop_d      = rop_q;
		rlen_d     = rlen_q;
		rcmd_d     = rcmd_q;
		rfirst_d   = rfirst_q;
		eop_d      = eop_q;
		ecmd_d     = ecmd_q;
		eign_d     = eign_q;
		tx_sum_d   = tx_sum_q;
		tx_left_d  = tx_left_q;
		bundle     = '0;
		dlen_s     = '0;
		hdr        = '0;
		sum_n      = '0;
		idx        = CW'(rx_count_q);
		rx_n       = idx + CW'(1);
		n          = '0;
		st         = ST_OK;

		case (req)
			REQ_START: begin
				dlen_s = ({1'b0, data_len} > MAX_DATA_BYTES) ? MAX_DATA_BYTES[5:0] : data_len;
				held_d = 1'b0;
				rop_d  = 1'b0;
				rlen_d = '0;
				rcmd_d = '0;
				eop_d  = op_write;
				ecmd_d = cmd_code;
				eign_d = ignore_errors;
				hdr    = {op_write, 1'b0, dlen_s};
				sum_n  = hdr + cmd_code;
				tx_sum_d  = sum_n;
				tx_left_d = dlen_s;
				bundle.res[0] = '{kind: KIND_TX, data: hdr, status: ST_OK, rlen: '0};
				bundle.res[1] = '{kind: KIND_TX, data: cmd_code, status: ST_OK, rlen: '0};
				if (dlen_s == '0) begin
					bundle.res[2] = '{kind: KIND_TX, data: 8'(-sum_n), status: ST_OK,
						rlen: '0};
					bundle.cnt = 2'd3;
				end else begin
					bundle.cnt = 2'd2;
				end
			end
			REQ_DATA: begin
				if (tx_left_q != '0) begin
					sum_n     = tx_sum_q + byte_value;
					tx_sum_d  = sum_n;
					tx_left_d = tx_left_q - 6'd1;
					bundle.res[0] = '{kind: KIND_TX, data: byte_value, status: ST_OK,
						rlen: '0};
					if (tx_left_q == 6'd1) begin
						bundle.res[1] = '{kind: KIND_TX, data: 8'(-sum_n), status: ST_OK,
							rlen: '0};
						bundle.cnt = 2'd2;
					end else begin
						bundle.cnt = 2'd1;
					end
				end
			end
			REQ_RX: begin
				if (idx >= RX_LIMIT || (held_q && idx >= CW'(rlen_q) + OVERHEAD)) begin
					// The byte does not fit: drop it and close the frame.
					rx_count_d = '0;
					bundle.res[0] = '{kind: KIND_DONE, data: '0, status: ST_OVERFLOW,
						rlen: rlen_q};
					bundle.cnt = 2'd1;
				end else begin
					if (idx == CW'(0) && !held_q) begin
						rop_d  = byte_value[7];
						rlen_d = byte_value[6:0];
					end else if (idx == CW'(1) && !held_q) begin
						rcmd_d = byte_value;
					end else if (idx == CW'(2)) begin
						rfirst_d = byte_value;
					end
					held_d = held_q | (rx_n >= CW'(2));
					if (idx >= CW'(2) && idx < CW'(rlen_d) + CW'(2)) begin
						bundle.res[n] = '{kind: KIND_RX_DATA, data: byte_value, status: ST_OK,
							rlen: '0};
						n = n + 2'd1;
					end
					if (held_d && rx_n == CW'(rlen_d) + OVERHEAD) begin
						if (rop_d != eop_q || rcmd_d != ecmd_q) begin
							st = ST_MISMATCH;
						end else if (!eign_q && (eop_q || rlen_d == 7'd1)) begin
							case (rfirst_d)
								DEV_UART_ERR_LO, DEV_UART_ERR_MID, DEV_UART_ERR_HI:
									st = ST_UART_ERR;
								DEV_UNSUPPORTED: st = ST_UNSUPPORTED;
								DEV_BAD_LENGTH:  st = ST_BAD_LENGTH;
								DEV_TOO_LONG:    st = ST_TOO_LONG;
								DEV_BAD_CHECK:   st = ST_BAD_CHECK;
								default:         st = ST_OK;
							endcase
						end
						rx_count_d = '0;
						bundle.res[n] = '{kind: KIND_DONE, data: '0, status: st, rlen: rlen_d};
						n = n + 2'd1;
					end else begin
						rx_count_d = rx_n[RW-1:0];
					end
					bundle.cnt = n;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_count_q <= '0;
			held_q     <= 1'b0;
			rop_q      <= 1'b0;
			rlen_q     <= '0;
			rcmd_q     <= '0;
			rfirst_q   <= '0;
			eop_q      <= 1'b0;
			ecmd_q     <= '0;
			eign_q     <= 1'b0;
			tx_sum_q   <= '0;
			tx_left_q  <= '0;
		end else if (en) begin
			rx_count_q <= rx_count_d;
			held_q     <= held_d;
			rop_q      <= rop_d;
			rlen_q     <= rlen_d;
			rcmd_q     <= rcmd_d;
			rfirst_q   <= rfirst_d;
			eop_q      <= eop_d;
			ecmd_q     <= ecmd_d;
			eign_q     <= eign_d;
			tx_sum_q   <= tx_sum_d;
			tx_left_q  <= tx_left_d;
		end
	end

endmodule
